>>> rtl/med3_pkg.sv
// Shared types, constants and the byte-lane sorting network of the 3x3 median filter.
package med3_pkg;

    localparam int PIX_W      = 32;
    localparam int LANE_W     = 8;
    localparam int LANES      = PIX_W / LANE_W;
    localparam int WIN_N      = 9;
    localparam int POS_W      = 27;
    localparam int LW_W       = 12;
    localparam int FR_W       = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    localparam logic [LW_W-1:0] LW_RESET = 12'd512;
    localparam logic [FR_W-1:0] FR_RESET = 14'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 1'b1;

    typedef logic [PIX_W-1:0]            t_pix;
    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;
    typedef logic [3:0]                  t_widx;

    function automatic t_pix lane_max(t_pix a, t_pix b);
        t_pix r;
        r = '0;
        for (int i = 0; i < LANES; i++) begin
            r[i*LANE_W +: LANE_W] = (a[i*LANE_W +: LANE_W] > b[i*LANE_W +: LANE_W]) ?
                                    a[i*LANE_W +: LANE_W] : b[i*LANE_W +: LANE_W];
        end
        return r;
    endfunction

    function automatic t_pix lane_min(t_pix a, t_pix b);
        t_pix r;
        r = '0;
        for (int i = 0; i < LANES; i++) begin
            r[i*LANE_W +: LANE_W] = (a[i*LANE_W +: LANE_W] < b[i*LANE_W +: LANE_W]) ?
                                    a[i*LANE_W +: LANE_W] : b[i*LANE_W +: LANE_W];
        end
        return r;
    endfunction

    // Compare-exchange: the low slot takes the lane minimum, the high slot the maximum.
    function automatic t_win exch(t_win v, t_widx lo, t_widx hi);
        t_win r;
        r     = v;
        r[lo] = lane_min(v[lo], v[hi]);
        r[hi] = lane_max(v[lo], v[hi]);
        return r;
    endfunction

    // First part of the network: the two independent sorting groups.
    function automatic t_win med_stage1(t_win v);
        t_win r;
        r = v;
        r = exch(r, 4'd0, 4'd1);
        r = exch(r, 4'd3, 4'd2);
        r = exch(r, 4'd2, 4'd0);
        r = exch(r, 4'd3, 4'd1);
        r = exch(r, 4'd1, 4'd0);
        r = exch(r, 4'd3, 4'd2);
        r = exch(r, 4'd5, 4'd4);
        r = exch(r, 4'd7, 4'd8);
        r = exch(r, 4'd6, 4'd8);
        r = exch(r, 4'd6, 4'd7);
        return r;
    endfunction

    function automatic t_win med_stage2(t_win v);
        t_win r;
        r = v;
        r = exch(r, 4'd4, 4'd8);
        r = exch(r, 4'd4, 4'd6);
        r = exch(r, 4'd5, 4'd7);
        r = exch(r, 4'd4, 4'd5);
        r = exch(r, 4'd6, 4'd7);
        r = exch(r, 4'd0, 4'd8);
        return r;
    endfunction

    function automatic t_pix med_stage3(t_win v);
        t_pix m4;
        t_pix m5;
        t_pix m6;
        t_pix m7;
        m4 = lane_max(v[0], v[4]);
        m5 = lane_max(v[1], v[5]);
        m6 = lane_max(v[2], v[6]);
        m7 = lane_max(v[3], v[7]);
        m4 = lane_min(m4, m6);
        m5 = lane_min(m5, m7);
        return lane_min(m4, m5);
    endfunction

endpackage

>>> rtl/med3_in_if.sv
// Pixel input channel: valid/ready handshake carrying one pixel beat.
interface med3_in_if import med3_pkg::*; ();
    logic       valid;
    logic       ready;
    t_pix       pixel;
    logic       first_of_frame;

    modport source (output valid, output pixel, output first_of_frame, input ready);
    modport sink   (input valid, input pixel, input first_of_frame, output ready);
endinterface

>>> rtl/med3_out_if.sv
// Median output channel: valid/ready handshake carrying one filtered pixel beat.
interface med3_out_if import med3_pkg::*; ();
    logic       valid;
    logic       ready;
    t_pix       median_pixel;
    logic       last_of_frame;

    modport source (output valid, output median_pixel, output last_of_frame, input ready);
    modport sink   (input valid, input median_pixel, input last_of_frame, output ready);
endinterface

>>> rtl/median_3x3_rgba_filter.sv
// 3x3 per-channel median filter over a raster stream of packed four-byte pixels.
//
// The block takes one pixel beat per clock while it is not recomputing and has output credit
// and, once past the top padding, returns at most one median beat per pixel. The median
// passes through the line-memory read stage, the sorting pipeline and the output queue
// before it is presented on the output. Both
// line delays live in one synchronous memory of MAX_LINE entries, each entry holding the
// pixel one line back and the pixel two lines back for a column; every accepted beat reads
// its column and the following cycle writes the shifted pair back, with a bypass for a
// beat that reads the column the previous beat is still writing. The column is tracked by a
// counter that wraps at the line width, so any width from 4 to MAX_LINE works. After reset
// and after every configuration write the input stalls while a one-bit-per-cycle remainder
// unit derives the column of the current position under the new width and the emit bounds
// are recomputed; a new width therefore takes effect cleanly mid-frame.
// The sorting network is split over three pipeline stages, and an eight-entry output queue
// with credit-based admission keeps the input flowing while the consumer stalls.
module median_3x3_rgba_filter import med3_pkg::*; #(
    parameter int MAX_LINE = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    med3_in_if.sink               i_pix,
    med3_out_if.source            o_med
);

    localparam int WW    = $clog2(MAX_LINE + 1);
    localparam int AW    = $clog2(MAX_LINE);
    localparam int CW    = ((WW > LW_W) ? WW : LW_W) + 1;
    localparam int EW    = POS_W + 1;
    localparam int PW    = FR_W + 1 + WW;
    localparam int CNT_W = $clog2(POS_W);
    localparam int FD    = 8;
    localparam int FP_W  = $clog2(FD);
    localparam int FC_W  = FP_W + 1;

    // Configuration registers.
    logic [LW_W-1:0] r_line_width;
    logic [FR_W-1:0] r_frame_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LW_RESET;
            r_frame_rows <= FR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data[LW_W-1:0];
                CFG_FRAME_ROWS: r_frame_rows <= i_cfg_data[FR_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective line width, clamped to the range the line memory supports.
    logic [WW-1:0] w_sat;

    always_comb begin
        if (CW'(r_line_width) < CW'(4)) begin
            w_sat = WW'(4);
        end else if (CW'(r_line_width) > CW'(MAX_LINE)) begin
            w_sat = WW'(MAX_LINE);
        end else begin
            w_sat = WW'(r_line_width);
        end
    end

    // Recompute pass: bounds and the column of the current position under the new width.
    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [WW-1:0]      r_rem;
    logic [WW-1:0]      r_w;
    logic [EW-1:0]      r_first;
    logic [EW-1:0]      r_last_e;
    logic [POS_W-1:0]   r_pos;
    logic [AW-1:0]      r_col;
    logic [CNT_W-1:0]   div_bit_idx;
    logic [WW:0]        div_trial;
    logic [WW:0]        div_next;
    logic [FR_W:0]      rows_p3;
    logic [PW-1:0]      last_prod;
    logic               busy_done;

    assign busy_done   = r_busy && (r_cnt == CNT_W'(POS_W - 1));
    assign div_bit_idx = CNT_W'(POS_W - 1) - r_cnt;
    assign div_trial   = {((r_cnt == '0) ? WW'(0) : r_rem), r_pos[div_bit_idx]};
    assign div_next    = (div_trial >= {1'b0, w_sat}) ? (div_trial - {1'b0, w_sat}) : div_trial;
    assign rows_p3     = {1'b0, r_frame_rows} + (FR_W + 1)'(3);
    assign last_prod   = PW'(rows_p3) * PW'(w_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (i_cfg_we) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (busy_done) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem    <= div_next[WW-1:0];
            r_w      <= w_sat;
            r_first  <= EW'(w_sat) * EW'(3) + EW'(1);
            r_last_e <= EW'(last_prod);
        end
    end

    // Input admission and position tracking.
    logic [FC_W-1:0]  r_fifo_cnt;
    logic             r_s1_valid;
    logic             r_s1_emit;
    logic             r_s2_valid;
    logic             r_s3_valid;
    logic             r_s4_valid;
    logic [FC_W-1:0]  credit_used;
    logic             acc;
    logic [POS_W-1:0] p_in;
    logic [AW-1:0]    col_in;
    logic             pos_sat;
    logic             col_wrap;
    logic [POS_W-1:0] n_pos;
    logic [AW-1:0]    n_col;
    logic             emit_in;
    logic             last_in;

    assign credit_used = r_fifo_cnt + FC_W'(r_s1_valid && r_s1_emit) + FC_W'(r_s2_valid)
                       + FC_W'(r_s3_valid) + FC_W'(r_s4_valid);
    assign i_pix.ready = !r_busy && !i_cfg_we && (credit_used < FC_W'(FD));
    assign acc         = i_pix.valid && i_pix.ready;

    assign p_in     = i_pix.first_of_frame ? '0 : r_pos;
    assign col_in   = i_pix.first_of_frame ? '0 : r_col;
    assign pos_sat  = &p_in;
    assign col_wrap = (WW'(col_in) + WW'(1)) == r_w;
    assign n_pos    = pos_sat ? p_in : p_in + POS_W'(1);
    assign n_col    = pos_sat ? col_in : (col_wrap ? '0 : col_in + AW'(1));
    assign emit_in  = (r_frame_rows != '0) && (EW'(p_in) >= r_first)
                   && (EW'(p_in) <= r_last_e);
    assign last_in  = EW'(p_in) == r_last_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_col <= '0;
        end else if (busy_done) begin
            r_col <= div_next[AW-1:0];
        end else if (acc) begin
            r_pos <= n_pos;
            r_col <= n_col;
        end
    end

    // Line memory: lower half is the pixel one line back, upper half two lines back.
    logic [2*PIX_W-1:0] r_lines [MAX_LINE];
    logic [2*PIX_W-1:0] r_rd;
    t_pix               r_s1_px;
    logic [AW-1:0]      r_s1_col;
    logic               r_s1_last;
    logic               r_s1_fwd;
    t_pix               r_s1_fa;
    t_pix               r_s1_fb;
    t_pix               s1_a;
    t_pix               s1_b;

    assign s1_a = r_s1_fwd ? r_s1_fa : r_rd[PIX_W-1:0];
    assign s1_b = r_s1_fwd ? r_s1_fb : r_rd[2*PIX_W-1:PIX_W];

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd <= r_lines[col_in];
        end
        if (r_s1_valid) begin
            r_lines[r_s1_col] <= {s1_a, r_s1_px};
        end
    end

    // Stage 1 holds the beat whose line-memory read is in flight. The bypass covers a beat
    // that reads the same column the stage-1 beat writes back at this very edge.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_px   <= i_pix.pixel;
            r_s1_col  <= col_in;
            r_s1_emit <= emit_in;
            r_s1_last <= last_in;
            r_s1_fwd  <= r_s1_valid && (r_s1_col == col_in);
            r_s1_fa   <= r_s1_px;
            r_s1_fb   <= s1_a;
        end
    end

    // Window: the two previous pixels of each of the three rows.
    t_pix r_win [6];
    t_win s1_v;

    always_comb begin
        s1_v[0] = r_win[1];
        s1_v[1] = r_win[0];
        s1_v[2] = s1_b;
        s1_v[3] = r_win[3];
        s1_v[4] = r_win[2];
        s1_v[5] = s1_a;
        s1_v[6] = r_win[5];
        s1_v[7] = r_win[4];
        s1_v[8] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win[1] <= r_win[0];
            r_win[0] <= s1_b;
            r_win[3] <= r_win[2];
            r_win[2] <= s1_a;
            r_win[5] <= r_win[4];
            r_win[4] <= r_s1_px;
        end
    end

    // Sorting network pipeline; only beats that produce a median travel on.
    t_win r_s2_v;
    t_win r_s3_v;
    t_win r_s4_v;
    logic r_s2_last;
    logic r_s3_last;
    logic r_s4_last;
    t_pix s4_med;

    assign s4_med = med_stage3(r_s4_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
            r_s2_valid <= r_s1_valid && r_s1_emit;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_v    <= s1_v;
        r_s2_last <= r_s1_last;
        r_s3_v    <= med_stage1(r_s2_v);
        r_s3_last <= r_s2_last;
        r_s4_v    <= med_stage2(r_s3_v);
        r_s4_last <= r_s3_last;
    end

    // Output queue. Admission counts every median beat in flight, so a push never finds
    // the queue full.
    t_pix            r_fifo_data [FD];
    logic            r_fifo_last [FD];
    logic [FP_W-1:0] r_wptr;
    logic [FP_W-1:0] r_rptr;
    logic            pop;

    assign o_med.valid        = r_fifo_cnt != '0;
    assign o_med.median_pixel = r_fifo_data[r_rptr];
    assign o_med.last_of_frame = r_fifo_last[r_rptr];
    assign pop                = o_med.valid && o_med.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (r_s4_valid) begin
                r_wptr <= r_wptr + FP_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FP_W'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + FC_W'(r_s4_valid) - FC_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s4_valid) begin
            r_fifo_data[r_wptr] <= s4_med;
            r_fifo_last[r_wptr] <= r_s4_last;
        end
    end

    // Checks.
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        credit_used <= FC_W'(FD))
        else $error("median beats in flight exceed the output queue depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> (r_fifo_cnt < FC_W'(FD)))
        else $error("push into a full output queue");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (WW'(r_col) < r_w))
        else $error("column counter outside the line width");

    a_emit_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && (r_frame_rows != '0)) |-> (r_last_e >= r_first))
        else $error("last emit position precedes first emit position");

    a_bypass_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_fwd) |-> $past(r_s1_valid))
        else $error("line memory bypass without a preceding beat");

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the 3x3 per-channel median filter.
`timescale 1ns / 1ps

module tb_top;
    import med3_pkg::*;

    localparam int          MAX_LINE      = 2048;
    localparam int unsigned POS_LIMIT     = (1 << POS_W) - 1;
    localparam int unsigned RANDOM_BEATS  = 340;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    // How a side of the handshake spaces its beats.
    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} t_idle_style;
    // Flavor of pixel content: fully random, extreme byte values, or a narrow
    // cluster of byte values that produces many ties inside the window.
    typedef enum int {TINT_FULL, TINT_EXTREMES, TINT_CLUSTER} t_pixel_tint;

    typedef struct packed {
        t_pix median;
        logic last;
    } t_median_beat;

    // Predicts the filtered stream and checks the medians that come out.
    class median_board;
        t_pix         delay_line [2*MAX_LINE];
        t_pix         tap_d1 [3];
        t_pix         tap_d2 [3];
        int unsigned  raster_pos;
        int unsigned  width_reg;
        int unsigned  rows_reg;
        int unsigned  mismatches;
        t_median_beat expected_medians [$];

        function new();
            width_reg  = int'(LW_RESET);
            rows_reg   = int'(FR_RESET);
            raster_pos = 0;
            mismatches = 0;
            foreach (delay_line[k]) delay_line[k] = '0;
            foreach (tap_d1[k]) begin
                tap_d1[k] = '0;
                tap_d2[k] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_LINE_WIDTH) begin
                width_reg = int'(data[LW_W-1:0]);
            end else if (idx == CFG_FRAME_ROWS) begin
                rows_reg = int'(data[FR_W-1:0]);
            end
        endfunction

        // Width as the block uses it: clamped to the range the line stores hold.
        function int unsigned line_len();
            if (width_reg < 4) return 4;
            if (width_reg > MAX_LINE) return MAX_LINE;
            return width_reg;
        endfunction

        // Byte-lane median by the same fixed compare-exchange network as the block.
        function t_pix median_of(t_pix win [9]);
            int         lo_slot [16] = '{0, 3, 2, 3, 1, 3, 5, 7, 6, 6, 4, 4, 5, 4, 6, 0};
            int         hi_slot [16] = '{1, 2, 0, 1, 0, 2, 4, 8, 8, 7, 8, 6, 7, 5, 7, 8};
            logic [7:0] s [9];
            logic [7:0] t;
            t_pix       r;
            r = '0;
            for (int lane = 0; lane < LANES; lane++) begin
                for (int k = 0; k < 9; k++) s[k] = win[k][lane*LANE_W +: LANE_W];
                for (int k = 0; k < 16; k++) begin
                    if (s[lo_slot[k]] > s[hi_slot[k]]) begin
                        t              = s[lo_slot[k]];
                        s[lo_slot[k]]  = s[hi_slot[k]];
                        s[hi_slot[k]]  = t;
                    end
                end
                s[4] = (s[0] > s[4]) ? s[0] : s[4];
                s[5] = (s[1] > s[5]) ? s[1] : s[5];
                s[6] = (s[2] > s[6]) ? s[2] : s[6];
                s[7] = (s[3] > s[7]) ? s[3] : s[7];
                s[4] = (s[4] < s[6]) ? s[4] : s[6];
                s[5] = (s[5] < s[7]) ? s[5] : s[7];
                r[lane*LANE_W +: LANE_W] = (s[4] < s[5]) ? s[4] : s[5];
            end
            return r;
        endfunction

        // Called for every pixel beat the block accepts.
        function void take_pixel(t_pix px, logic first);
            int unsigned     w;
            int unsigned     p;
            int unsigned     col;
            longint unsigned first_c;
            longint unsigned last_c;
            t_pix            one_back;
            t_pix            two_back;
            t_pix            win [9];
            t_median_beat    beat;
            w          = line_len();
            p          = first ? 0 : raster_pos;
            raster_pos = (p < POS_LIMIT) ? p + 1 : POS_LIMIT;

            col                       = p % w;
            one_back                  = delay_line[col];
            two_back                  = delay_line[MAX_LINE + col];
            delay_line[MAX_LINE + col] = one_back;
            delay_line[col]           = px;

            win[0] = tap_d2[0]; win[1] = tap_d1[0]; win[2] = two_back;
            win[3] = tap_d2[1]; win[4] = tap_d1[1]; win[5] = one_back;
            win[6] = tap_d2[2]; win[7] = tap_d1[2]; win[8] = px;
            tap_d2[0] = tap_d1[0]; tap_d1[0] = two_back;
            tap_d2[1] = tap_d1[1]; tap_d1[1] = one_back;
            tap_d2[2] = tap_d1[2]; tap_d1[2] = px;

            first_c = 3 * longint'(w) + 1;
            last_c  = (longint'(rows_reg) + 3) * longint'(w);
            if (rows_reg != 0 && p >= first_c && p <= last_c) begin
                beat.median = median_of(win);
                beat.last   = (p == last_c);
                expected_medians.push_back(beat);
            end
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // Called for every median beat the testbench accepts.
        task compare_median(t_pix got_median, logic got_last);
            t_median_beat want;
            if (expected_medians.size() == 0) begin
                report($sformatf("unexpected median %h last %b", got_median, got_last));
            end else begin
                want = expected_medians.pop_front();
                if (got_median !== want.median)
                    report($sformatf("median %h, predicted %h", got_median, want.median));
                if (got_last !== want.last)
                    report($sformatf("last_of_frame %b, predicted %b", got_last, want.last));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           cycle_count = 0;
    int unsigned           random_beats;
    t_idle_style           in_idle;
    t_idle_style           out_idle;
    median_board           board = new();

    med3_in_if  pix_if ();
    med3_out_if med_if ();

    median_3x3_rgba_filter #(.MAX_LINE(MAX_LINE)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_med      (med_if)
    );

    always #6 i_clk = ~i_clk;

    // Hard stop in case the block hangs or stops producing medians.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Every handshake is sampled right after the rising edge, before any
    // nonblocking update of that edge lands, so both sides see pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && med_if.valid && med_if.ready)
            board.compare_median(med_if.median_pixel, med_if.last_of_frame);
    end

    function automatic int unsigned draw_gap(t_idle_style style);
        case (style)
            IDLE_FULL:   return $urandom_range(0, 15);
            IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
            default:     return 0;
        endcase
    endfunction

    function automatic t_pix draw_pixel(t_pixel_tint tint);
        t_pix       px;
        logic [7:0] b;
        for (int lane = 0; lane < LANES; lane++) begin
            case (tint)
                TINT_EXTREMES: begin
                    case ($urandom_range(0, 4))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        2:       b = 8'h7F;
                        3:       b = 8'h80;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                end
                TINT_CLUSTER: b = 8'($urandom_range(8'h7C, 8'h83));
                default:      b = 8'($urandom_range(0, 255));
            endcase
            px[lane*LANE_W +: LANE_W] = b;
        end
        return px;
    endfunction

    // Consumer side: before every median beat, drop ready for a gap drawn from the output idle style.
    initial begin
        int unsigned gap;
        med_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_gap(out_idle);
            if (gap != 0) begin
                med_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            med_if.ready <= 1'b1;
            do @(posedge i_clk); while (!med_if.valid);
        end
    end

    // Both registers are written back to back while the block is idle. The
    // write enable drops only after the second write, so it never toggles twice
    // within one time step.
    task automatic configure(logic [CFG_DATA_W-1:0] width_raw,
                             logic [CFG_DATA_W-1:0] rows_raw);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LINE_WIDTH;
        cfg_data <= width_raw;
        @(posedge i_clk);
        board.set_reg(CFG_LINE_WIDTH, width_raw);
        cfg_idx  <= CFG_FRAME_ROWS;
        cfg_data <= rows_raw;
        @(posedge i_clk);
        board.set_reg(CFG_FRAME_ROWS, rows_raw);
        cfg_we   <= 1'b0;
    endtask

    // One pixel beat. Valid is lowered only when a gap is drawn, so a beat that
    // follows directly keeps valid high without a low/high pair in one step.
    task automatic send_pixel(t_pix px, logic first);
        int unsigned gap;
        gap = draw_gap(in_idle);
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid          <= 1'b1;
        pix_if.pixel          <= px;
        pix_if.first_of_frame <= first;
        do @(posedge i_clk); while (!pix_if.ready);
        board.take_pixel(px, first);
    endtask

    // A frame of len beats. With restarts enabled an occasional beat inside the
    // frame carries a start mark as well, which breaks the frame off early.
    task automatic stream_frame(int unsigned len, bit marked, bit restarts,
                                t_pixel_tint tint);
        logic first;
        for (int unsigned i = 0; i < len; i++) begin
            first = (i == 0) ? marked : (restarts && $urandom_range(0, 255) == 0);
            send_pixel(draw_pixel(tint), first);
            random_beats++;
        end
    endtask

    // Drop valid, wait for every predicted median, then let the pipeline run dry:
    // beats past the frame end produce no median but may still be in flight.
    task automatic settle();
        int unsigned waited;
        waited = 0;
        pix_if.valid <= 1'b0;
        while (board.expected_medians.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_pix        directed [8];
        int unsigned phase;
        int unsigned width_raw;
        int unsigned rows_raw;
        int unsigned w_eff;
        int unsigned full_len;
        int unsigned len;
        int unsigned n_frames;
        t_pixel_tint tint;

        directed = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8080_8080, 32'h7F7F_7F7F,
                     32'h01FE_01FE, 32'hFE01_FE01, 32'h00FF_7F80, 32'hFF00_807F};
        random_beats = 0;
        in_idle      = IDLE_NONE;
        out_idle     = IDLE_FULL;

        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= CFG_LINE_WIDTH;
        cfg_data              <= '0;
        pix_if.valid          <= 1'b0;
        pix_if.pixel          <= '0;
        pix_if.first_of_frame <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: a width below the minimum (clamped to four pixels), one
        // filtered row, and no start mark at all, so the first beat after reset
        // has to take position zero on its own. The frame is twenty pixels; two
        // more follow past its end and must not produce a median. The values rotate through
        // all-zero, all-one, mid-scale and mixed-lane extremes, lane-masked from index ten on.
        configure(14'd3, 14'd1);
        for (int i = 0; i < 22; i++) begin
            send_pixel(directed[(i * 3) % 8] ^ ((i >= 10) ? 32'h0F0F_F0F0 : 32'h0), 1'b0);
        end
        settle();

        // Random part: small frames under many settings. Each phase programs
        // both registers while idle and then sends one to three marked frames
        // that are complete, cut short, or followed by stray beats past the end.
        // Phase zero forces zero rows; phase one forces a width of zero.
        phase        = 0;
        random_beats = 0;
        while (random_beats < RANDOM_BEATS) begin
            case ($urandom_range(0, 9))
                0:       width_raw = $urandom_range(0, 3);
                9:       width_raw = $urandom_range(13, 33);
                default: width_raw = $urandom_range(4, 12);
            endcase
            rows_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            if (phase == 0) rows_raw = 0;
            if (phase == 1) width_raw = 0;
            configure(CFG_DATA_W'(width_raw), CFG_DATA_W'(rows_raw));
            w_eff    = board.line_len();
            full_len = (rows_raw + 4) * w_eff;

            in_idle  = t_idle_style'($urandom_range(0, 2));
            out_idle = t_idle_style'($urandom_range(0, 2));
            tint     = t_pixel_tint'($urandom_range(0, 2));
            n_frames = $urandom_range(1, 3);
            for (int f = 0; f < n_frames; f++) begin
                case ($urandom_range(0, 9))
                    0, 1:    len = $urandom_range(3 * w_eff + 2, full_len - 1);
                    2:       len = full_len + $urandom_range(1, 6);
                    default: len = full_len;
                endcase
                stream_frame(len, 1'b1, 1'b1, tint);
            end
            settle();
            phase++;
        end

        // Register extremes. All-ones data masks to a width of 4095, which the
        // block clamps to the line store size, with the largest row count; only
        // a short start of that frame is sent, well before its first median, so
        // nothing may come out.
        in_idle  = IDLE_NONE;
        out_idle = IDLE_FULL;
        configure(14'h3FFF, 14'h3FFF);
        stream_frame(24, 1'b1, 1'b0, TINT_FULL);
        settle();

        // The narrowest line with only the top bit of the row count set, again cut short.
        in_idle  = IDLE_FULL;
        out_idle = IDLE_FULL;
        configure(14'd4, 14'd8192);
        stream_frame(3 * 4 + 2 + 30, 1'b1, 1'b0, TINT_CLUSTER);
        settle();

        if (board.expected_medians.size() != 0)
            board.report($sformatf("%0d predicted medians never arrived",
                                   board.expected_medians.size()));
        if (board.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/med3_pkg.sv
rtl/med3_in_if.sv
rtl/med3_out_if.sv
rtl/median_3x3_rgba_filter.sv
bench/tb_top.sv
